// ===== rtl/lcs_pkg.sv =====
// Shared constants, types and the best-match compare for the longest common substring unit.
package lcs_pkg;

    localparam int CELLS       = 256;
    localparam int CELL_IDX_W  = $clog2(CELLS);
    localparam int REF_CNT_W   = CELL_IDX_W + 1;
    localparam int LEN_W       = 9;
    localparam int START_W     = 16;
    localparam int QUERY_CNT_W = START_W + 1;
    localparam int BYTE_W      = 8;
    localparam int M_DATA_W    = 32;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [START_W-1:0] row;
    } best_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic              step;
        logic              clear;
        logic [BYTE_W-1:0] qbyte;
        logic [START_W-1:0] row;
        logic              ref_clr;
        logic [BYTE_W-1:0] wdata;
    } cell_ctrl_t;

    // A longer run wins; of equal runs the one from the earlier query row wins.
    function automatic best_t best_of(best_t a, best_t b);
        best_t r;
        r = a;
        if (b.len > a.len) begin
            r = b;
        end else if ((b.len == a.len) && (b.row < a.row)) begin
            r = b;
        end
        return r;
    endfunction

endpackage

// ===== rtl/lcs_cell.sv =====
// One reference position: its byte, its diagonal run, its own best run and one reduction stage.
module lcs_cell import lcs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctrl_t           ctrl,
    input  logic                 wr_sel,
    input  logic [LEN_W-1:0]     left_run,
    input  best_t                chain_in,
    output logic [LEN_W-1:0]     run_out,
    output best_t                chain_out
);

    logic [BYTE_W-1:0] ref_byte_reg;
    logic              active_reg;
    logic              active_next;
    logic [LEN_W-1:0]  run_reg;
    logic [LEN_W-1:0]  run_next;
    best_t             best_reg;
    best_t             best_next;
    best_t             chain_reg;
    logic [LEN_W-1:0]  prev_run;
    best_t             best_base;
    logic              match;

    always_comb begin
        active_next = active_reg;
        if (ctrl.ref_clr) begin
            active_next = 1'b0;
        end
        if (wr_sel) begin
            active_next = 1'b1;
        end
    end

    // The left neighbor's run still holds the previous query row here.
    always_comb begin
        prev_run  = ctrl.clear ? '0 : left_run;
        best_base = ctrl.clear ? best_t'('0) : best_reg;
        match     = active_reg && (ref_byte_reg == ctrl.qbyte);
        run_next  = match ? LEN_W'(prev_run + LEN_W'(1)) : '0;
        best_next = best_base;
        if (run_next > best_base.len) begin
            best_next.len = run_next;
            best_next.row = ctrl.row;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_sel) begin
            ref_byte_reg <= ctrl.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            run_reg    <= '0;
            best_reg   <= '0;
            chain_reg  <= '0;
        end else begin
            active_reg <= active_next;
            if (ctrl.step) begin
                run_reg  <= run_next;
                best_reg <= best_next;
            end
            chain_reg <= best_of(best_reg, chain_in);
        end
    end

    assign run_out   = run_reg;
    assign chain_out = chain_reg;

endmodule

// ===== rtl/longest_common_substring_unit.sv =====
// Top level of the longest common substring unit: control, row of cells and result register.
// Load items (tuser 0) append reference bytes, up to 256; the item with tlast set ends
// the load, and the next load item starts a new reference. Query items (tuser 1) stream
// the other string, one byte per cycle while no reduction runs, and every cell updates
// its diagonal run at once. Load items are also taken one per cycle while no reduction runs.
// A final query item starts a reduction, during which the input takes no item: the best
// run is reduced through the 256-stage chain that runs along the cells before the result
// is written to the output register. The reduction also waits while that register still
// holds a previous result that has not been taken. Result tdata holds the match length
// and the start offset in the query (modulo 2^16); no match gives zero for both.
module longest_common_substring_unit import lcs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,   // last
    input  logic                s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [8:0] match_length, [24:9] match_start
);

    typedef enum logic [1:0] {
        ST_RUN    = 2'b01,
        ST_REDUCE = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [REF_CNT_W-1:0]   ref_len_reg, ref_len_next;
    logic                   load_done_reg, load_done_next;
    logic [QUERY_CNT_W-1:0] qidx_reg, qidx_next;
    logic [REF_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]       m_len_reg;
    logic [START_W-1:0]     m_start_reg;

    logic                   s_fire;
    logic                   is_load;
    logic                   new_ref;
    logic [REF_CNT_W-1:0]   base_len;
    logic                   ref_wr;
    logic                   reduce_done;
    logic                   out_load;
    cell_ctrl_t             ctrl;

    logic [LEN_W-1:0]       run_w   [CELLS];
    best_t                  chain_w [CELLS];
    best_t                  final_best;
    logic [START_W-1:0]     final_start;

    assign s_tready    = (state_reg == ST_RUN);
    assign s_fire      = s_tvalid && s_tready;
    assign is_load     = (opcode_t'(s_tuser) == OP_LOAD);
    assign new_ref     = load_done_reg;
    assign base_len    = new_ref ? '0 : ref_len_reg;
    assign ref_wr      = s_fire && is_load && !base_len[REF_CNT_W-1];
    assign reduce_done = (cnt_reg == REF_CNT_W'(CELLS));
    assign out_load    = (state_reg == ST_REDUCE) && reduce_done && (!m_valid_reg || m_tready);

    always_comb begin
        ctrl.step    = s_fire && !is_load && !qidx_reg[QUERY_CNT_W-1];
        ctrl.clear   = (qidx_reg == '0);
        ctrl.qbyte   = s_tdata;
        ctrl.row     = qidx_reg[START_W-1:0];
        ctrl.ref_clr = s_fire && is_load && new_ref;
        ctrl.wdata   = s_tdata;
    end

    always_comb begin
        state_next     = state_reg;
        ref_len_next   = ref_len_reg;
        load_done_next = load_done_reg;
        qidx_next      = qidx_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        if (m_tvalid && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_RUN: begin
                if (s_fire) begin
                    if (is_load) begin
                        qidx_next      = '0;
                        ref_len_next   = ref_wr ? REF_CNT_W'(base_len + REF_CNT_W'(1))
                                                : base_len;
                        load_done_next = s_tlast ? 1'b1 : (new_ref ? 1'b0 : load_done_reg);
                    end else if (s_tlast) begin
                        qidx_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_REDUCE;
                    end else if (ctrl.step) begin
                        qidx_next = QUERY_CNT_W'(qidx_reg + QUERY_CNT_W'(1));
                    end
                end
            end
            ST_REDUCE: begin
                if (!reduce_done) begin
                    cnt_next = REF_CNT_W'(cnt_reg + REF_CNT_W'(1));
                end
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            ref_len_reg   <= '0;
            load_done_reg <= 1'b0;
            qidx_reg      <= '0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ref_len_reg   <= ref_len_next;
            load_done_reg <= load_done_next;
            qidx_reg      <= qidx_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < CELLS; j++) begin : g_cell
            logic             wr_sel;
            logic [LEN_W-1:0] left_run;
            best_t            chain_in;

            assign wr_sel = ref_wr && (base_len[CELL_IDX_W-1:0] == CELL_IDX_W'(j));
            if (j == 0) begin : g_head
                assign left_run = '0;
                assign chain_in = '0;
            end else begin : g_body
                assign left_run = run_w[j-1];
                assign chain_in = chain_w[j-1];
            end

            lcs_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .wr_sel    (wr_sel),
                .left_run  (left_run),
                .chain_in  (chain_in),
                .run_out   (run_w[j]),
                .chain_out (chain_w[j])
            );
        end
    endgenerate

    // The run ending on query row r with length n started at row r + 1 - n.
    assign final_best  = chain_w[CELLS-1];
    assign final_start = (final_best.len == '0) ? '0 :
                         START_W'(final_best.row + START_W'(1) - START_W'(final_best.len));

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_len_reg   <= final_best.len;
            m_start_reg <= final_start;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - LEN_W - START_W){1'b0}}, m_start_reg, m_len_reg};

endmodule

// ===== rtl/lcs_checker.sv =====
// Port-level checks for the longest common substring unit and the bind that attaches them.
module lcs_checker import lcs_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [BYTE_W-1:0]   s_tdata,
    input logic                s_tlast,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A waiting result item holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // The final query item starts the reduction, which takes no item.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_QUERY) && s_tlast |=> !s_tready)
        else $error("item taken during reduction");

    // No match means a zero start offset, and a run never exceeds the cell count.
    a_empty_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[LEN_W-1:0] == '0) |-> (m_tdata[LEN_W+START_W-1:LEN_W] == '0))
        else $error("nonzero start with zero length");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[LEN_W-1:0] <= LEN_W'(CELLS))
                     && (m_tdata[M_DATA_W-1:LEN_W+START_W] == '0))
        else $error("result length out of range");

endmodule

bind longest_common_substring_unit lcs_checker u_lcs_checker (.*);
